// ----- hw/rtl/assert_macros.svh -----
// ----------------------------------------------------------------------------
// assert_macros.svh
// shared concurrent assertion macros, clocked with an active-low reset
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ACFM_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define ACFM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hw/rtl/acfm_pkg.sv -----
// ----------------------------------------------------------------------------
// acfm_pkg
// shared types and constants of the adaptive cumulative frequency model
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package acfm_pkg;

    localparam int NUM_SYMBOLS_DEF = 256;
    localparam int COUNT_BITS_DEF  = 16;
    localparam int OUT_BITS        = 16;
    localparam int SYMBOL_BITS     = 8;

    // operation codes
    localparam logic OP_ENCODE = 1'b0;
    localparam logic OP_CLEAR  = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_WALK,
        ST_CLEAR
    } acfm_state_t;

    // controller to datapath
    typedef struct packed {
        logic start;         // encode item accepted, load walk state
        logic clear;         // clear item accepted, drop all node entries
        logic step;          // move one tree level down
        logic commit;        // target node reached, update and load result
        logic commit_clear;  // load result of a clear item
    } acfm_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic at_target;
    } acfm_status_t;

endpackage

`default_nettype wire

// ----- hw/rtl/acfm_req_if.sv -----
// ----------------------------------------------------------------------------
// acfm_req_if
// input channel: operation and symbol with valid/ready
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface acfm_req_if
    import acfm_pkg::*;
;
    logic                   valid;
    logic                   ready;
    logic                   operation;
    logic [SYMBOL_BITS-1:0] symbol;

    modport source (output valid, output operation, output symbol, input ready);
    modport sink   (input valid, input operation, input symbol, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/acfm_rsp_if.sv -----
// ----------------------------------------------------------------------------
// acfm_rsp_if
// result channel: cumulative range, total and flags with valid/ready
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface acfm_rsp_if
    import acfm_pkg::*;
;
    logic                valid;
    logic                ready;
    logic [OUT_BITS-1:0] low_bound;
    logic [OUT_BITS-1:0] high_bound;
    logic [OUT_BITS-1:0] total;
    logic                first_seen;
    logic                saturated;

    modport source (output valid, output low_bound, output high_bound, output total,
                    output first_seen, output saturated, input ready);
    modport sink   (input valid, input low_bound, input high_bound, input total,
                    input first_seen, input saturated, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/adaptive_cumulative_frequency_model.sv -----
// ----------------------------------------------------------------------------
// adaptive_cumulative_frequency_model
// adaptive symbol frequency tree giving cumulative ranges to a range coder
// ----------------------------------------------------------------------------
// An encode item walks the implicit search tree of NUM_SYMBOLS nodes (root
// at NUM_SYMBOLS/2, node 0 below node 1), visiting one node per cycle, and
// returns the symbol's range [low_bound, high_bound), the running total and
// the first-seen and saturated flags. The walk is paced by the node ram,
// which is read once per level and written at most once per level through
// its one read and one write port. The result waits in an output register,
// so the next item is taken while it is still unread; a finished walk then
// holds until the register frees up. Counts reset to zero through per-entry
// valid bits, so neither reset nor clear needs a sweep of the ram.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module adaptive_cumulative_frequency_model
    import acfm_pkg::*;
#(
    parameter int NUM_SYMBOLS = NUM_SYMBOLS_DEF,  // power of two, 16 to 4096
    parameter int COUNT_BITS  = COUNT_BITS_DEF    // 8 to 32
) (
    input  wire logic clk,
    input  wire logic rst_n,
    acfm_req_if.sink  req,
    acfm_rsp_if.source rsp
);

    acfm_cmd_t    cmd;
    acfm_status_t status;

    // sequencer: handshakes, walk stepping, output register valid
    acfm_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (req.valid),
        .in_operation (req.operation),
        .in_ready     (req.ready),
        .out_valid    (rsp.valid),
        .out_ready    (rsp.ready),
        .status       (status),
        .cmd          (cmd)
    );

    // node memory, walk arithmetic and result payload
    acfm_datapath #(
        .NUM_SYMBOLS (NUM_SYMBOLS),
        .COUNT_BITS  (COUNT_BITS)
    ) u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .status     (status),
        .symbol     (req.symbol),
        .low_bound  (rsp.low_bound),
        .high_bound (rsp.high_bound),
        .total      (rsp.total),
        .first_seen (rsp.first_seen),
        .saturated  (rsp.saturated)
    );

endmodule

`default_nettype wire

// ----- hw/rtl/acfm_ram.sv -----
// ----------------------------------------------------------------------------
// acfm_ram
// generic simple dual-port ram, one write port, one registered read port
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module acfm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

// ----- hw/rtl/acfm_ctrl.sv -----
// ----------------------------------------------------------------------------
// acfm_ctrl
// sequencer: accepts items, steps the tree walk, owns the result valid
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module acfm_ctrl
    import acfm_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         in_valid,
    input  wire logic         in_operation,
    output logic              in_ready,
    output logic              out_valid,
    input  wire logic         out_ready,
    input  wire acfm_status_t status,
    output acfm_cmd_t         cmd
);

    acfm_state_t state_reg;
    acfm_state_t state_next;
    logic        out_valid_reg;
    logic        out_valid_next;
    logic        out_free;
    logic        out_load;

    assign out_free  = !out_valid_reg || out_ready;
    assign out_valid = out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        out_load   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    unique case (in_operation)
                        OP_ENCODE:
                        begin
                            cmd.start  = 1'b1;
                            state_next = ST_WALK;
                        end
                        OP_CLEAR:
                        begin
                            cmd.clear  = 1'b1;
                            state_next = ST_CLEAR;
                        end
                    endcase
                end
            end
            ST_WALK:
            begin
                if (!status.at_target)
                begin
                    cmd.step = 1'b1;
                end
                else if (out_free)
                begin
                    cmd.commit = 1'b1;
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            ST_CLEAR:
            begin
                if (out_free)
                begin
                    cmd.commit_clear = 1'b1;
                    out_load         = 1'b1;
                    state_next       = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

endmodule

`default_nettype wire

// ----- hw/rtl/acfm_datapath.sv -----
// ----------------------------------------------------------------------------
// acfm_datapath
// node ram, per-entry valid bits, walk registers and result registers
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module acfm_datapath
    import acfm_pkg::*;
#(
    parameter int NUM_SYMBOLS = NUM_SYMBOLS_DEF,
    parameter int COUNT_BITS  = COUNT_BITS_DEF
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire acfm_cmd_t              cmd,
    output acfm_status_t                status,
    input  wire logic [SYMBOL_BITS-1:0] symbol,
    output logic      [OUT_BITS-1:0]    low_bound,
    output logic      [OUT_BITS-1:0]    high_bound,
    output logic      [OUT_BITS-1:0]    total,
    output logic                        first_seen,
    output logic                        saturated
);

    localparam int AddrBits = $clog2(NUM_SYMBOLS);
    localparam logic [AddrBits-1:0] RootNode  = AddrBits'(NUM_SYMBOLS / 2);
    localparam logic [AddrBits-1:0] FirstStep = AddrBits'(NUM_SYMBOLS / 4);

    // walk state
    logic [AddrBits-1:0]   sym_reg;
    logic [AddrBits-1:0]   node_reg;
    logic [AddrBits-1:0]   step_reg;
    logic [COUNT_BITS-1:0] low_reg;
    logic                  sat_reg;
    logic [COUNT_BITS-1:0] total_reg;
    logic [COUNT_BITS-1:0] total_next;

    // entry valid bits, an invalid entry reads as zero counts
    logic [NUM_SYMBOLS-1:0] valid_reg;
    logic                   rd_valid_reg;

    // result registers
    logic [OUT_BITS-1:0] low_bound_reg;
    logic [OUT_BITS-1:0] high_bound_reg;
    logic [OUT_BITS-1:0] total_out_reg;
    logic                first_seen_reg;
    logic                saturated_reg;

    // ram ports, entry layout is {left subtree count, node count}
    logic                    ram_wr_en;
    logic [AddrBits-1:0]     ram_wr_addr;
    logic [2*COUNT_BITS-1:0] ram_wr_data;
    logic                    ram_rd_en;
    logic [AddrBits-1:0]     ram_rd_addr;
    logic [2*COUNT_BITS-1:0] ram_rd_data;

    logic [COUNT_BITS-1:0] cur_cnt;
    logic [COUNT_BITS-1:0] cur_left;
    logic [COUNT_BITS-1:0] cnt_new;
    logic [COUNT_BITS-1:0] low_final;
    logic [COUNT_BITS-1:0] high_final;
    logic                  go_left;
    logic [AddrBits-1:0]   next_node;

    acfm_ram #(
        .WIDTH (2 * COUNT_BITS),
        .DEPTH (NUM_SYMBOLS)
    ) u_node_ram (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    assign cur_cnt  = rd_valid_reg ? ram_rd_data[COUNT_BITS-1:0] : '0;
    assign cur_left = rd_valid_reg ? ram_rd_data[2*COUNT_BITS-1:COUNT_BITS] : '0;

    assign go_left          = sym_reg < node_reg;
    assign status.at_target = sym_reg == node_reg;

    // node 0 hangs under node 1, reached when the step has run out
    always_comb
    begin
        if (go_left)
        begin
            next_node = (step_reg == '0) ? '0 : node_reg - step_reg;
        end
        else
        begin
            next_node = node_reg + step_reg;
        end
    end

    assign cnt_new    = sat_reg ? cur_cnt : cur_cnt + 1'b1;
    assign low_final  = low_reg + cur_left;
    assign high_final = low_final + cnt_new;
    assign total_next = sat_reg ? total_reg : total_reg + 1'b1;

    assign ram_rd_en   = cmd.start || cmd.step;
    assign ram_rd_addr = cmd.start ? RootNode : next_node;
    assign ram_wr_en   = !sat_reg && ((cmd.step && go_left) || cmd.commit);
    assign ram_wr_addr = node_reg;
    assign ram_wr_data = cmd.commit ? {cur_left, cnt_new} : {cur_left + 1'b1, cur_cnt};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            total_reg <= '0;
        end
        else
        begin
            if (cmd.clear)
            begin
                valid_reg <= '0;
            end
            else if (ram_wr_en)
            begin
                valid_reg[ram_wr_addr] <= 1'b1;
            end
            if (cmd.commit)
            begin
                total_reg <= total_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ram_rd_en)
        begin
            rd_valid_reg <= valid_reg[ram_rd_addr];
        end
        if (cmd.start)
        begin
            sym_reg  <= AddrBits'(symbol);
            node_reg <= RootNode;
            step_reg <= FirstStep;
            low_reg  <= '0;
            sat_reg  <= total_reg == '1;
        end
        else if (cmd.step)
        begin
            node_reg <= next_node;
            step_reg <= step_reg >> 1;
            if (!go_left)
            begin
                low_reg <= low_reg + cur_left + cur_cnt;
            end
        end
        if (cmd.commit)
        begin
            low_bound_reg  <= OUT_BITS'(low_final);
            high_bound_reg <= OUT_BITS'(high_final);
            total_out_reg  <= OUT_BITS'(total_next);
            first_seen_reg <= cur_cnt == '0;
            saturated_reg  <= sat_reg;
        end
        else if (cmd.commit_clear)
        begin
            low_bound_reg  <= '0;
            high_bound_reg <= '0;
            total_out_reg  <= OUT_BITS'(total_reg);
            first_seen_reg <= 1'b0;
            saturated_reg  <= 1'b0;
        end
    end

    assign low_bound  = low_bound_reg;
    assign high_bound = high_bound_reg;
    assign total      = total_out_reg;
    assign first_seen = first_seen_reg;
    assign saturated  = saturated_reg;

endmodule

`default_nettype wire

// ----- hw/rtl/acfm_checker.sv -----
// ----------------------------------------------------------------------------
// acfm_checker
// port-level checks of the frequency model, bound to the top level
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module acfm_checker
    import acfm_pkg::*;
(
    input wire logic                clk,
    input wire logic                rst_n,
    input wire logic                req_valid,
    input wire logic                req_ready,
    input wire logic                rsp_valid,
    input wire logic                rsp_ready,
    input wire logic [OUT_BITS-1:0] rsp_low_bound,
    input wire logic [OUT_BITS-1:0] rsp_high_bound,
    input wire logic [OUT_BITS-1:0] rsp_total,
    input wire logic                rsp_first_seen,
    input wire logic                rsp_saturated
);

    logic                req_fire;
    logic                rsp_stall;
    logic [OUT_BITS-1:0] range_width;

    assign req_fire    = req_valid && req_ready;
    assign rsp_stall   = rsp_valid && !rsp_ready;
    assign range_width = rsp_high_bound - rsp_low_bound;

    // a stalled result keeps its payload
    `ACFM_ASSERT_NEXT(a_rsp_hold, clk, rst_n, rsp_stall, rsp_valid && $stable(rsp_low_bound) && $stable(rsp_high_bound) && $stable(rsp_total), "result changed while stalled")

    // one item in work at a time
    `ACFM_ASSERT_NEXT(a_one_in_work, clk, rst_n, req_fire, !req_ready, "item taken right after another")

    // a newly seen symbol that was counted has a range of one
    `ACFM_ASSERT_IMPLY(a_first_width, clk, rst_n, rsp_valid && rsp_first_seen && !rsp_saturated, range_width == OUT_BITS'(1), "first-seen range is not one")

    // saturation only reported with the total at its limit
    `ACFM_ASSERT_IMPLY(a_sat_total, clk, rst_n, rsp_valid && rsp_saturated, rsp_total == '1, "saturated with total below limit")

endmodule

bind adaptive_cumulative_frequency_model acfm_checker u_acfm_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .req_valid      (req.valid),
    .req_ready      (req.ready),
    .rsp_valid      (rsp.valid),
    .rsp_ready      (rsp.ready),
    .rsp_low_bound  (rsp.low_bound),
    .rsp_high_bound (rsp.high_bound),
    .rsp_total      (rsp.total),
    .rsp_first_seen (rsp.first_seen),
    .rsp_saturated  (rsp.saturated)
);

`default_nettype wire

// ----- dv/tb_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the adaptive cumulative frequency model
// ----------------------------------------------------------------------------
// A scoreboard keeps its own copy of the frequency tree and works out the
// cumulative range, total and flags for every accepted item, then checks
// each returned result against the oldest pending one. Stimulus runs a
// short directed sweep, a random mix of encodes and clears with random
// gaps and stalls, a long result-side hold, and a short tail of edge
// symbols around a final clear.
// ----------------------------------------------------------------------------

module tb_top;
    import acfm_pkg::*;

    localparam int CLK_PERIOD   = 4;
    localparam int RANDOM_ITEMS = 1400;
    localparam int MAX_IDLE     = 12;
    localparam int LONG_HOLD    = 300;   // result-side hold that backs up the input
    localparam int STALL_LIMIT  = 2000;  // cycles with no handshake before giving up
    localparam int DRAIN_CYCLES = 20;
    localparam int PRINT_CAP    = 40;    // mismatch lines printed before going quiet

    localparam bit [COUNT_BITS_DEF-1:0] COUNT_LIMIT = '1;

    // one result of the block, field for field
    typedef struct packed {
        logic [OUT_BITS-1:0] low_bound;
        logic [OUT_BITS-1:0] high_bound;
        logic [OUT_BITS-1:0] total;
        logic                first_seen;
        logic                saturated;
    } coded_range_t;

    // ------------------------------------------------------------------------
    // scoreboard: frequency tree copy plus the queue of pending ranges
    // ------------------------------------------------------------------------
    class freq_scoreboard;
        bit [COUNT_BITS_DEF-1:0] sym_count    [NUM_SYMBOLS_DEF];
        bit [COUNT_BITS_DEF-1:0] subtree_below [NUM_SYMBOLS_DEF];
        bit [COUNT_BITS_DEF-1:0] coded_total;
        coded_range_t            pending_ranges[$];
        int                      mismatches;
        int                      items_in;
        int                      clears_in;
        int                      ranges_checked;
        int                      saturated_seen;

        // predict one item: a clear drops the local copy, an encode walks the tree and updates it
        function coded_range_t predict_range(logic op, logic [SYMBOL_BITS-1:0] sym);
            coded_range_t            r;
            int unsigned             node;
            int unsigned             stride;
            bit [COUNT_BITS_DEF-1:0] lo;
            bit [COUNT_BITS_DEF-1:0] cnt;
            bit                      full;
            r = '0;
            if (op == OP_CLEAR)
            begin
                foreach (sym_count[i])
                begin
                    sym_count[i]     = '0;
                    subtree_below[i] = '0;
                end
                r.total = coded_total;
                return r;
            end
            full   = (coded_total == COUNT_LIMIT);
            node   = NUM_SYMBOLS_DEF / 2;
            stride = NUM_SYMBOLS_DEF / 4;
            lo     = '0;
            while (node != sym)
            begin
                if (sym < node)
                begin
                    if (!full)
                        subtree_below[node] = subtree_below[node] + 1'b1;
                    // below node 1 the stride is spent and node 0 hangs there
                    node = (stride == 0) ? 0 : node - stride;
                end
                else
                begin
                    lo   = lo + subtree_below[node] + sym_count[node];
                    node = node + stride;
                end
                stride = stride >> 1;
            end
            cnt          = sym_count[sym];
            r.first_seen = (cnt == 0);
            if (!full)
            begin
                cnt            = cnt + 1'b1;
                sym_count[sym] = cnt;
                coded_total    = coded_total + 1'b1;
            end
            lo           = lo + subtree_below[sym];
            r.low_bound  = lo;
            r.high_bound = lo + cnt;
            r.total      = coded_total;
            r.saturated  = full;
            return r;
        endfunction

        function void note_item(logic op, logic [SYMBOL_BITS-1:0] sym);
            items_in++;
            if (op == OP_CLEAR)
                clears_in++;
            pending_ranges.push_back(predict_range(op, sym));
        endfunction

        function int pending();
            return pending_ranges.size();
        endfunction

        task report_mismatch(string msg);
            mismatches++;
            if (mismatches <= PRINT_CAP)
                $display("[%0t] mismatch: %s", $realtime, msg);
        endtask

        task check_field(string name, int idx, logic [OUT_BITS-1:0] want,
                         logic [OUT_BITS-1:0] seen);
            if (seen !== want)
                report_mismatch($sformatf("result %0d %s got %h expected %h",
                                          idx, name, seen, want));
        endtask

        task check_item(coded_range_t got);
            coded_range_t want;
            if (pending_ranges.size() == 0)
            begin
                report_mismatch($sformatf("result %0d arrived with nothing pending",
                                          ranges_checked));
                ranges_checked++;
                return;
            end
            want = pending_ranges.pop_front();
            check_field("low_bound",  ranges_checked, want.low_bound,  got.low_bound);
            check_field("high_bound", ranges_checked, want.high_bound, got.high_bound);
            check_field("total",      ranges_checked, want.total,      got.total);
            check_field("first_seen", ranges_checked, want.first_seen, got.first_seen);
            check_field("saturated",  ranges_checked, want.saturated,  got.saturated);
            if (want.saturated)
                saturated_seen++;
            ranges_checked++;
        endtask
    endclass

    logic clk;
    logic rst_n;

    acfm_req_if req_ch ();
    acfm_rsp_if rsp_ch ();

    adaptive_cumulative_frequency_model dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    freq_scoreboard sb = new();

    // idling controls, changed per phase by the stimulus
    bit tx_idle;
    bit rx_idle;
    bit hold_rsp;   // ask the result side for one long hold

    int quiet_cycles;

    initial clk = 1'b0;
    always #(CLK_PERIOD / 2) clk = ~clk;

    // ------------------------------------------------------------------------
    // send one item; entered and left at a rising edge, leaves after accept
    // ------------------------------------------------------------------------
    task automatic send_item(logic op, logic [SYMBOL_BITS-1:0] sym);
        int gap;
        gap = tx_idle ? $urandom_range(0, MAX_IDLE) : 0;
        if (gap > 0)
        begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        // with no gap valid just stays high for the next item
        req_ch.valid     <= 1'b1;
        req_ch.operation <= op;
        req_ch.symbol    <= sym;
        do
            @(posedge clk);
        while (!req_ch.ready);
        sb.note_item(op, sym);
    endtask

    // symbols skewed toward the tree's edges and a few hot values, so that
    // some counts grow large while every bit still toggles
    function automatic logic [SYMBOL_BITS-1:0] pick_symbol();
        logic [SYMBOL_BITS-1:0] edge_syms [7] = '{0, 1, 127, 128, 129, 254, 255};
        case ($urandom_range(0, 9))
            0:       return edge_syms[$urandom_range(0, 6)];
            1, 2:    return SYMBOL_BITS'($urandom_range(0, 7) * 37);
            default: return SYMBOL_BITS'($urandom_range(0, NUM_SYMBOLS_DEF - 1));
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // result side: random stall before each item, one long hold on request
    // ------------------------------------------------------------------------
    initial
    begin
        int           stall;
        coded_range_t got;
        @(posedge rst_n);
        @(posedge clk);
        forever
        begin
            if (hold_rsp)
            begin
                hold_rsp = 1'b0;
                stall    = LONG_HOLD;
            end
            else
                stall = rx_idle ? $urandom_range(0, MAX_IDLE) : 0;
            if (stall > 0)
            begin
                rsp_ch.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            rsp_ch.ready <= 1'b1;
            do
                @(posedge clk);
            while (!rsp_ch.valid);
            got.low_bound  = rsp_ch.low_bound;
            got.high_bound = rsp_ch.high_bound;
            got.total      = rsp_ch.total;
            got.first_seen = rsp_ch.first_seen;
            got.saturated  = rsp_ch.saturated;
            sb.check_item(got);
        end
    end

    // ------------------------------------------------------------------------
    // watchdog: too long without any handshake ends the run
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("watchdog: no handshake for %0d cycles, %0d results pending",
                         quiet_cycles, sb.pending());
                $display("simulation failed");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------------
    initial
    begin
        int   phase;
        logic op;
        rst_n            = 1'b0;
        req_ch.valid     = 1'b0;
        req_ch.operation = OP_ENCODE;
        req_ch.symbol    = '0;
        rsp_ch.ready     = 1'b0;
        tx_idle          = 1'b1;
        rx_idle          = 1'b1;
        hold_rsp         = 1'b0;
        quiet_cycles     = 0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed sweep: tree edges, node 0 under node 1, repeats, clears
        send_item(OP_ENCODE, 8'd0);     // deepest left leaf, first seen
        send_item(OP_ENCODE, 8'd255);   // deepest right leaf
        send_item(OP_ENCODE, 8'd128);   // root
        send_item(OP_ENCODE, 8'd1);
        send_item(OP_ENCODE, 8'd0);     // seen before now
        send_item(OP_ENCODE, 8'd127);
        send_item(OP_ENCODE, 8'd129);
        send_item(OP_ENCODE, 8'd64);
        send_item(OP_ENCODE, 8'd192);
        send_item(OP_ENCODE, 8'd2);
        send_item(OP_ENCODE, 8'd254);
        send_item(OP_ENCODE, 8'd255);
        send_item(OP_ENCODE, 8'd85);
        send_item(OP_ENCODE, 8'd170);
        send_item(OP_CLEAR,  8'd255);   // symbol bits ignored on clear
        send_item(OP_ENCODE, 8'd0);     // first seen again, total kept
        send_item(OP_ENCODE, 8'd128);
        send_item(OP_ENCODE, 8'd128);
        send_item(OP_CLEAR,  8'd0);
        send_item(OP_CLEAR,  8'd170);   // back-to-back clears
        send_item(OP_ENCODE, 8'd255);
        send_item(OP_ENCODE, 8'd127);

        // random mix in four quarters: both idle, sender only, receiver only,
        // none; the long result hold lands in the receiver-only quarter while
        // the sender offers items back to back
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            phase   = n / (RANDOM_ITEMS / 4);
            tx_idle = (phase == 0) || (phase == 1);
            rx_idle = (phase == 0) || (phase == 2);
            if (n == (RANDOM_ITEMS / 2) + 10)
                hold_rsp = 1'b1;
            op = ($urandom_range(0, 39) == 0) ? OP_CLEAR : OP_ENCODE;
            send_item(op, pick_symbol());
        end

        // tail: edge walks over grown counts, then a clear and walks over
        // empty counts
        tx_idle = 1'b1;
        rx_idle = 1'b1;
        send_item(OP_ENCODE, 8'd0);
        send_item(OP_ENCODE, 8'd255);
        send_item(OP_ENCODE, 8'd128);
        for (int n = 0; n < 8; n++)
            send_item(OP_ENCODE, pick_symbol());
        send_item(OP_CLEAR, pick_symbol());
        send_item(OP_ENCODE, 8'd0);
        send_item(OP_ENCODE, 8'd255);
        for (int n = 0; n < 8; n++)
            send_item(OP_ENCODE, pick_symbol());
        req_ch.valid <= 1'b0;

        // drain, then give the block a little longer to show stray results
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("covered %0d items including %0d clears; %0d results checked",
                 sb.items_in, sb.clears_in, sb.ranges_checked);
        $display("total reached %0d, %0d results returned saturated, %0d mismatches",
                 sb.coded_total, sb.saturated_seen, sb.mismatches);
        if (sb.mismatches == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

// ----- files.f -----
+incdir+hw/rtl
hw/rtl/acfm_pkg.sv
hw/rtl/acfm_req_if.sv
hw/rtl/acfm_rsp_if.sv
hw/rtl/acfm_ram.sv
hw/rtl/acfm_ctrl.sv
hw/rtl/acfm_datapath.sv
hw/rtl/adaptive_cumulative_frequency_model.sv
hw/rtl/acfm_checker.sv
dv/tb_top.sv
